// ===== rtl/lpu_pkg.sv =====
// shared types and constants for the length-prefixed utf-8 deframer
// no dependencies; used by every module under rtl
package lpu_pkg;

  // prefix length and register reset value
  localparam int unsigned PREFIX_BYTES_DEFAULT = 4;
  localparam logic [23:0] MAX_FRAME_LENGTH_RST = 24'h10_0000;

  // frame verdict codes
  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_TOO_LARGE = 2'd1,
    STATUS_BAD_UTF8  = 2'd2
  } status_t;

  // extra check applied to the second byte of a sequence
  typedef enum logic [2:0] {
    RULE_NONE   = 3'd0,
    RULE_MIN_A0 = 3'd1,
    RULE_MAX_9F = 3'd2,
    RULE_MIN_90 = 3'd3,
    RULE_MAX_8F = 3'd4
  } rule_t;

  // decoder context carried between payload bytes
  typedef struct packed {
    logic [1:0] pending;
    rule_t      rule;
  } utf8_state_t;

  // one result item
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       frame_end;
    status_t    status;
  } result_t;

endpackage

// ===== rtl/lpu_utf8_check.sv =====
// utf-8 byte checker: next decoder context and error flag for one byte
// depends on lpu_pkg
module lpu_utf8_check (
  input  logic [7:0]          byte_in,
  input  lpu_pkg::utf8_state_t cur,
  output lpu_pkg::utf8_state_t nxt,
  output logic                fail
);

  // continuation or lead byte classification
  always_comb begin
    nxt  = cur;
    fail = 1'b0;
    if (cur.pending != 2'd0) begin
      fail = (byte_in[7:6] != 2'b10);
      unique case (cur.rule)
        lpu_pkg::RULE_MIN_A0: if (byte_in < 8'hA0) fail = 1'b1;
        lpu_pkg::RULE_MAX_9F: if (byte_in > 8'h9F) fail = 1'b1;
        lpu_pkg::RULE_MIN_90: if (byte_in < 8'h90) fail = 1'b1;
        lpu_pkg::RULE_MAX_8F: if (byte_in > 8'h8F) fail = 1'b1;
        default: ;
      endcase
      nxt.rule    = lpu_pkg::RULE_NONE;
      nxt.pending = cur.pending - 2'd1;
    end else if (byte_in <= 8'h7F) begin
      fail = 1'b0;
    end else if (byte_in >= 8'hC2 && byte_in <= 8'hDF) begin
      nxt.pending = 2'd1;
    end else if (byte_in >= 8'hE0 && byte_in <= 8'hEF) begin
      nxt.pending = 2'd2;
      if (byte_in == 8'hE0) nxt.rule = lpu_pkg::RULE_MIN_A0;
      else if (byte_in == 8'hED) nxt.rule = lpu_pkg::RULE_MAX_9F;
    end else if (byte_in >= 8'hF0 && byte_in <= 8'hF4) begin
      nxt.pending = 2'd3;
      if (byte_in == 8'hF0) nxt.rule = lpu_pkg::RULE_MIN_90;
      else if (byte_in == 8'hF4) nxt.rule = lpu_pkg::RULE_MAX_8F;
    end else begin
      fail = 1'b1;
    end
  end

endmodule

// ===== rtl/lpu_deframe_core.sv =====
// frame state and per-byte result logic: header parse, length check, utf-8 verdict
// depends on lpu_pkg and lpu_utf8_check
module lpu_deframe_core #(
  parameter int unsigned PREFIX_BYTES = lpu_pkg::PREFIX_BYTES_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             proc_en,
  input  logic [7:0]       proc_byte,
  input  logic [23:0]      max_len,
  output logic             res_valid,
  output lpu_pkg::result_t res,
  output logic             halted
);

  logic [2:0]           header_count, header_count_next;
  logic [31:0]          length_accumulator, length_accumulator_next;
  logic [23:0]          bytes_remaining, bytes_remaining_next;
  lpu_pkg::utf8_state_t utf8_state, utf8_state_next, chk_next;
  logic                 utf8_bad, utf8_bad_next;
  lpu_pkg::status_t     sticky_error, sticky_error_next;
  logic                 chk_fail;
  logic [31:0]          acc_shift;
  logic [2:0]           count_inc;

  lpu_utf8_check u_check (
    .byte_in (proc_byte),
    .cur     (utf8_state),
    .nxt     (chk_next),
    .fail    (chk_fail)
  );

  assign acc_shift = {length_accumulator[23:0], proc_byte};
  assign count_inc = header_count + 3'd1;
  assign halted    = (sticky_error != lpu_pkg::STATUS_OK);

  // next state and result for the byte leaving the input register
  always_comb begin
    header_count_next       = header_count;
    length_accumulator_next = length_accumulator;
    bytes_remaining_next    = bytes_remaining;
    utf8_state_next         = utf8_state;
    utf8_bad_next           = utf8_bad;
    sticky_error_next       = sticky_error;
    res_valid               = 1'b0;
    res.data_byte           = 8'd0;
    res.has_byte            = 1'b0;
    res.frame_end           = 1'b1;
    res.status              = lpu_pkg::STATUS_OK;
    if (!halted) begin
      if (bytes_remaining == 24'd0) begin
        // header phase
        length_accumulator_next = acc_shift;
        header_count_next       = count_inc;
        if (count_inc >= 3'(PREFIX_BYTES)) begin
          header_count_next       = 3'd0;
          length_accumulator_next = 32'd0;
          if (acc_shift > {8'd0, max_len}) begin
            sticky_error_next = lpu_pkg::STATUS_TOO_LARGE;
            res_valid         = 1'b1;
            res.status        = lpu_pkg::STATUS_TOO_LARGE;
          end else begin
            bytes_remaining_next = acc_shift[23:0];
            utf8_state_next      = '{pending: 2'd0, rule: lpu_pkg::RULE_NONE};
            utf8_bad_next        = 1'b0;
            res_valid            = (acc_shift[23:0] == 24'd0);
          end
        end
      end else begin
        // payload phase
        if (!utf8_bad) begin
          utf8_state_next = chk_next;
          utf8_bad_next   = chk_fail;
        end
        bytes_remaining_next = bytes_remaining - 24'd1;
        res_valid            = 1'b1;
        res.data_byte        = proc_byte;
        res.has_byte         = 1'b1;
        res.frame_end        = (bytes_remaining == 24'd1);
        if (bytes_remaining == 24'd1) begin
          if (utf8_state_next.pending != 2'd0) utf8_bad_next = 1'b1;
          if (utf8_bad_next) sticky_error_next = lpu_pkg::STATUS_BAD_UTF8;
          utf8_state_next = '{pending: 2'd0, rule: lpu_pkg::RULE_NONE};
        end
        res.status = utf8_bad_next ? lpu_pkg::STATUS_BAD_UTF8 : lpu_pkg::STATUS_OK;
        if (bytes_remaining == 24'd1) utf8_bad_next = 1'b0;
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      header_count       <= 3'd0;
      length_accumulator <= 32'd0;
      bytes_remaining    <= 24'd0;
      utf8_state         <= '{pending: 2'd0, rule: lpu_pkg::RULE_NONE};
      utf8_bad           <= 1'b0;
      sticky_error       <= lpu_pkg::STATUS_OK;
    end else if (proc_en) begin
      header_count       <= header_count_next;
      length_accumulator <= length_accumulator_next;
      bytes_remaining    <= bytes_remaining_next;
      utf8_state         <= utf8_state_next;
      utf8_bad           <= utf8_bad_next;
      sticky_error       <= sticky_error_next;
    end
  end

endmodule

// ===== rtl/length_prefixed_utf8_deframer.sv =====
// length-prefixed frame deframer with streaming utf-8 validation, top level
// an input byte reaches the result port through the input register, then the result register
// throughput: one byte per cycle, set by the single-pass input-to-result register stage
// stalls on the master side back up through the input register
// reset: synchronous active-high rst clears frame state and sticky error, restores max length
// depends on lpu_pkg and lpu_deframe_core
module length_prefixed_utf8_deframer #(
  parameter int unsigned PREFIX_BYTES = lpu_pkg::PREFIX_BYTES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // data_byte
  output logic        m_axis_tlast,   // frame_end
  output logic [2:0]  m_axis_tuser,   // status[1:0], has_byte
  input  logic        cfg_wen,
  input  logic [23:0] cfg_wdata       // max_frame_length
);

  logic             in_valid;
  logic [7:0]       in_byte;
  logic             out_valid;
  lpu_pkg::result_t out_res;
  logic [23:0]      max_frame_length;
  logic             advance;
  logic             res_valid;
  lpu_pkg::result_t res;
  logic             halted;

  // input register moves on when the result register is free or draining
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_length <= lpu_pkg::MAX_FRAME_LENGTH_RST;
    end else if (cfg_wen) begin
      max_frame_length <= cfg_wdata;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
    end
  end

  lpu_deframe_core #(
    .PREFIX_BYTES (PREFIX_BYTES)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .proc_en   (advance),
    .proc_byte (in_byte),
    .max_len   (max_frame_length),
    .res_valid (res_valid),
    .res       (res),
    .halted    (halted)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res_valid;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_res.data_byte;
  assign m_axis_tlast  = out_res.frame_end;
  assign m_axis_tuser  = {out_res.status, out_res.has_byte};

`ifndef SYNTHESIS
  // an error stops the block until reset
  a_halt_sticks: assert property (@(posedge clk) disable iff (rst)
    halted |=> halted)
    else $error("sticky error cleared without reset");

  // an empty result slot always lets the next byte in
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> s_axis_tready)
    else $error("input stalled while result register empty");

  // a result without a payload byte is always a frame end marker
  a_marker_is_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast)
    else $error("byte-less result without frame end");

  // too-large verdict never rides on a payload byte
  a_too_large_no_byte: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser[2:1] == lpu_pkg::STATUS_TOO_LARGE) |-> !m_axis_tuser[0])
    else $error("too-large status on a payload byte");
`endif

endmodule

// ===== tb/length_prefixed_utf8_deframer_tb.sv =====
// self-checking testbench for the length-prefixed utf-8 deframer
// drives framed byte streams, predicts every result transfer and checks it field by field
// depends on lpu_pkg and length_prefixed_utf8_deframer
`timescale 1ns / 100ps

module length_prefixed_utf8_deframer_tb;

  localparam int PREFIX      = lpu_pkg::PREFIX_BYTES_DEFAULT;
  localparam int PHASE_BYTES = 240;
  localparam int STALL_LIMIT = 2000;
  localparam int REPORT_MAX  = 10;

  // clock, reset and block ports; the ones the bench drives are known from time zero
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // rx_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b1;
  logic [7:0]  m_axis_tdata;           // data_byte
  logic        m_axis_tlast;           // frame_end
  logic [2:0]  m_axis_tuser;           // status[1:0], has_byte
  logic        cfg_wen = 1'b0;
  logic [23:0] cfg_wdata = 24'h0;

  // byte stream waiting to be sent, and results still due from the block
  logic [7:0]       rx_stream[$];
  logic [7:0]       payload_buf[$];
  lpu_pkg::result_t frame_results_due[$];
  int               bytes_queued = 0;
  int               bytes_sent = 0;
  int               mismatches = 0;
  int               quiet_cycles = 0;

  // deframer model state
  logic [2:0]           hdr_count;
  logic [31:0]          len_shift;
  logic [23:0]          payload_left;
  lpu_pkg::utf8_state_t utf8_ctx;
  logic                 frame_bad;
  lpu_pkg::status_t     halt_code;
  logic [23:0]          max_len;

  // sender pacing and receiver stall pattern
  int               burst_left = 0;
  int               gap_left = 0;
  logic [15:0]      ready_phase = 16'h0;
  lpu_pkg::result_t head_result;

  length_prefixed_utf8_deframer u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // returns 1 when the byte breaks utf-8 in the current decoder context
  function automatic bit utf8_breaks(input logic [7:0] b);
    bit fail;
    fail = 1'b0;
    if (utf8_ctx.pending != 2'd0) begin
      fail = (b[7:6] != 2'b10);
      if (!fail) begin
        case (utf8_ctx.rule)
          lpu_pkg::RULE_MIN_A0: fail = (b < 8'hA0);
          lpu_pkg::RULE_MAX_9F: fail = (b > 8'h9F);
          lpu_pkg::RULE_MIN_90: fail = (b < 8'h90);
          lpu_pkg::RULE_MAX_8F: fail = (b > 8'h8F);
          default: fail = 1'b0;
        endcase
      end
      utf8_ctx.rule    = lpu_pkg::RULE_NONE;
      utf8_ctx.pending = utf8_ctx.pending - 2'd1;
    end else if (b <= 8'h7F) begin
      fail = 1'b0;
    end else if (b >= 8'hC2 && b <= 8'hDF) begin
      utf8_ctx.pending = 2'd1;
    end else if (b >= 8'hE0 && b <= 8'hEF) begin
      utf8_ctx.pending = 2'd2;
      if (b == 8'hE0) utf8_ctx.rule = lpu_pkg::RULE_MIN_A0;
      else if (b == 8'hED) utf8_ctx.rule = lpu_pkg::RULE_MAX_9F;
    end else if (b >= 8'hF0 && b <= 8'hF4) begin
      utf8_ctx.pending = 2'd3;
      if (b == 8'hF0) utf8_ctx.rule = lpu_pkg::RULE_MIN_90;
      else if (b == 8'hF4) utf8_ctx.rule = lpu_pkg::RULE_MAX_8F;
    end else begin
      fail = 1'b1;
    end
    return fail;
  endfunction

  // advance the model by one accepted byte, queueing any result it causes
  function automatic void deframe_byte(input logic [7:0] b);
    lpu_pkg::result_t r;
    r = '0;
    if (halt_code != lpu_pkg::STATUS_OK) return;
    if (payload_left == 24'd0) begin
      // header phase: shift in the big-endian length
      len_shift = {len_shift[23:0], b};
      hdr_count = hdr_count + 3'd1;
      if (hdr_count < PREFIX) return;
      hdr_count   = 3'd0;
      r.frame_end = 1'b1;
      if (len_shift > {8'h00, max_len}) begin
        halt_code = lpu_pkg::STATUS_TOO_LARGE;
        len_shift = '0;
        r.status  = lpu_pkg::STATUS_TOO_LARGE;
        frame_results_due = {frame_results_due, r};
        return;
      end
      payload_left = len_shift[23:0];
      len_shift    = '0;
      utf8_ctx     = '{pending: 2'd0, rule: lpu_pkg::RULE_NONE};
      frame_bad    = 1'b0;
      if (payload_left == 24'd0) begin
        r.status = lpu_pkg::STATUS_OK;
        frame_results_due = {frame_results_due, r};
      end
      return;
    end
    // payload phase: pass the byte through with the running verdict
    if (!frame_bad && utf8_breaks(b)) frame_bad = 1'b1;
    payload_left = payload_left - 24'd1;
    r.data_byte  = b;
    r.has_byte   = 1'b1;
    if (payload_left == 24'd0) begin
      if (utf8_ctx.pending != 2'd0) frame_bad = 1'b1;
      r.frame_end = 1'b1;
      r.status    = frame_bad ? lpu_pkg::STATUS_BAD_UTF8 : lpu_pkg::STATUS_OK;
      if (frame_bad) halt_code = lpu_pkg::STATUS_BAD_UTF8;
      utf8_ctx  = '{pending: 2'd0, rule: lpu_pkg::RULE_NONE};
      frame_bad = 1'b0;
    end else begin
      r.status = frame_bad ? lpu_pkg::STATUS_BAD_UTF8 : lpu_pkg::STATUS_OK;
    end
    frame_results_due = {frame_results_due, r};
  endfunction

  // stimulus helpers
  function automatic void push_rx(input logic [7:0] b);
    rx_stream = {rx_stream, b};
    bytes_queued++;
  endfunction

  function automatic void add_payload(input logic [7:0] b);
    payload_buf = {payload_buf, b};
  endfunction

  function automatic void put_header(input logic [31:0] n);
    int k;
    for (k = PREFIX - 1; k >= 0; k--) push_rx(n[8*k +: 8]);
  endfunction

  function automatic void send_payload();
    put_header(32'(payload_buf.size()));
    foreach (payload_buf[k]) push_rx(payload_buf[k]);
    payload_buf.delete();
  endfunction

  // one well-formed code point no longer than room bytes
  function automatic int put_char(input int room);
    int         size;
    int         k;
    logic [7:0] lead;
    logic [7:0] lo;
    logic [7:0] hi;
    size = $urandom_range(1, (room < 4) ? room : 4);
    lo   = 8'h80;
    hi   = 8'hBF;
    case (size)
      1: lead = 8'($urandom_range(8'h00, 8'h7F));
      2: lead = 8'($urandom_range(8'hC2, 8'hDF));
      3: lead = 8'($urandom_range(8'hE0, 8'hEF));
      default: lead = 8'($urandom_range(8'hF0, 8'hF4));
    endcase
    // second byte limits against overlong forms, surrogates and the top of the code space
    if (lead == 8'hE0) lo = 8'hA0;
    if (lead == 8'hED) hi = 8'h9F;
    if (lead == 8'hF0) lo = 8'h90;
    if (lead == 8'hF4) hi = 8'h8F;
    add_payload(lead);
    if (size > 1) add_payload(8'($urandom_range(lo, hi)));
    for (k = 2; k < size; k++) add_payload(8'($urandom_range(8'h80, 8'hBF)));
    return size;
  endfunction

  function automatic void fill_valid(input int n);
    int left;
    left = n;
    while (left > 0) left -= put_char(left);
  endfunction

  // mostly short frames, now and then a longer one or one of exactly the limit
  function automatic int pick_length(input logic [23:0] lim);
    int r;
    int cap;
    r   = $urandom_range(0, 15);
    if (lim <= 300 && r == 0) return int'(lim);
    cap = (r == 1) ? 300 : 24;
    if (cap > lim) cap = int'(lim);
    return $urandom_range(0, cap);
  endfunction

  task automatic wait_drained();
    do @(negedge clk);
    while (bytes_sent != bytes_queued || frame_results_due.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_limit(input logic [23:0] v);
    @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= v;
    max_len    = v;
    @(posedge clk);
    cfg_wen <= 1'b0;
    @(negedge clk);
  endtask

  // sender: bursts of random length with random gaps
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (gap_left != 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (rx_stream.size() != 0) begin
        s_axis_tdata  <= rx_stream.pop_front();
        s_axis_tvalid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 48);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver: stall mode follows bits 9:8 of a free-running phase counter
  always @(posedge clk) begin
    ready_phase <= ready_phase + 16'd1;
    case (ready_phase[9:8])
      2'd0: m_axis_tready <= 1'b1;
      2'd1: m_axis_tready <= ($urandom_range(0, 3) != 0);
      2'd2: m_axis_tready <= (ready_phase[2:0] < 3'd5);
      default: m_axis_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // monitor: check result transfers, feed accepted input transfers to the model
  always @(posedge clk) begin
    if (rst) begin
      hdr_count    = 3'd0;
      len_shift    = '0;
      payload_left = '0;
      utf8_ctx     = '{pending: 2'd0, rule: lpu_pkg::RULE_NONE};
      frame_bad    = 1'b0;
      halt_code    = lpu_pkg::STATUS_OK;
      max_len      = lpu_pkg::MAX_FRAME_LENGTH_RST;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (frame_results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("unexpected result transfer: data %02h last %b user %03b",
                     m_axis_tdata, m_axis_tlast, m_axis_tuser);
        end else begin
          head_result = frame_results_due.pop_front();
          if (m_axis_tdata !== head_result.data_byte ||
              m_axis_tuser[0] !== head_result.has_byte ||
              m_axis_tlast !== head_result.frame_end ||
              m_axis_tuser[2:1] !== head_result.status) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display({"result mismatch: exp data %02h has %b end %b status %0d, ",
                        "got data %02h has %b end %b status %0d"},
                       head_result.data_byte, head_result.has_byte, head_result.frame_end,
                       head_result.status, m_axis_tdata, m_axis_tuser[0], m_axis_tlast,
                       m_axis_tuser[2:1]);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        bytes_sent++;
        deframe_byte(s_axis_tdata);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // stimulus sequence
  initial begin
    logic [23:0] limits[6];
    int          p;
    int          phase_start;
    int          defect;
    int          n;
    logic [7:0]  lead;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty frame, then the boundary code points of every sequence length
    put_header(32'd0);
    payload_buf = '{8'h7F, 8'hC2, 8'h80, 8'hE0, 8'hA0, 8'h80, 8'hED, 8'h9F, 8'hBF,
                    8'hF0, 8'h90, 8'h80, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
    send_payload();
    // sender holds off until every result is back
    wait_drained();

    // random frames under a series of length limits, extremes included
    limits[0] = 24'd0;
    limits[1] = 24'hFF_FFFF;
    limits[2] = 24'd1;
    limits[3] = 24'($urandom_range(2, 40));
    limits[4] = lpu_pkg::MAX_FRAME_LENGTH_RST;
    limits[5] = 24'($urandom_range(64, 5000));
    for (p = 0; p < 6; p++) begin
      write_limit(limits[p]);
      phase_start = bytes_queued;
      while (bytes_queued - phase_start < PHASE_BYTES) begin
        fill_valid(pick_length(limits[p]));
        send_payload();
      end
      wait_drained();
    end

    // closing frame carries the one error the run can take, since errors hold until reset
    defect = $urandom_range(0, 7);
    if (defect == 0) begin
      case ($urandom_range(0, 2))
        0: put_header({8'h00, limits[5]} + 32'd1);
        1: put_header({8'($urandom_range(1, 255)), 24'($urandom)});
        default: put_header(32'hFFFF_FFFF);
      endcase
    end else begin
      fill_valid($urandom_range(0, 6));
      case (defect)
        1: add_payload($urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hC1))
                                            : 8'($urandom_range(8'hF5, 8'hFF)));
        2: begin
          add_payload(8'($urandom_range(8'hC2, 8'hF4)));
          add_payload($urandom_range(0, 1) ? 8'($urandom_range(8'h00, 8'h7F))
                                           : 8'($urandom_range(8'hC0, 8'hFF)));
        end
        3: begin
          add_payload(8'hE0);
          add_payload(8'($urandom_range(8'h80, 8'h9F)));
          add_payload(8'($urandom_range(8'h80, 8'hBF)));
        end
        4: begin
          add_payload(8'hED);
          add_payload(8'($urandom_range(8'hA0, 8'hBF)));
          add_payload(8'($urandom_range(8'h80, 8'hBF)));
        end
        5: begin
          add_payload(8'hF0);
          add_payload(8'($urandom_range(8'h80, 8'h8F)));
          add_payload(8'($urandom_range(8'h80, 8'hBF)));
          add_payload(8'($urandom_range(8'h80, 8'hBF)));
        end
        6: begin
          add_payload(8'hF4);
          add_payload(8'($urandom_range(8'h90, 8'hBF)));
          add_payload(8'($urandom_range(8'h80, 8'hBF)));
          add_payload(8'($urandom_range(8'h80, 8'hBF)));
        end
        default: begin
          // sequence cut off by the frame end
          n = $urandom_range(2, 4);
          case (n)
            2: lead = 8'($urandom_range(8'hC2, 8'hDF));
            3: lead = 8'($urandom_range(8'hE1, 8'hEC));
            default: lead = 8'($urandom_range(8'hF1, 8'hF3));
          endcase
          add_payload(lead);
          repeat ($urandom_range(0, n - 2))
            add_payload(8'($urandom_range(8'h80, 8'hBF)));
        end
      endcase
      if (defect != 7) fill_valid($urandom_range(0, 6));
      send_payload();
    end
    // bytes after the error are taken and dropped
    repeat (20) push_rx(8'($urandom_range(0, 255)));
    wait_drained();

    if (mismatches == 0 && frame_results_due.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
